@@ design/ptl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection trip logic package
// Shared types, constants and level helpers for the protection trip logic.
// ----------------------------------------------------------------------------
package ptl_pkg;

   localparam int LEVEL_WIDTH    = 16;
   localparam int DETECTOR_COUNT = 8;
   localparam int CMP_WIDTH      = (LEVEL_WIDTH > 16) ? LEVEL_WIDTH : 16;
   localparam int COND_COUNT     = 6;
   localparam int MASK_WIDTH     = 8;
   localparam int COUNT_WIDTH    = 4;
   localparam int QUEUE_DEPTH    = 2;

   localparam int B_OVERPOWER = 0;
   localparam int B_PERIOD    = 1;
   localparam int B_FLOW      = 2;
   localparam int B_VOID      = 3;
   localparam int B_SENSOR    = 4;
   localparam int B_MANUAL    = 5;

   localparam int LVL_ALARM_SET = 0;
   localparam int LVL_ALARM_CLR = 1;
   localparam int LVL_TRIP_SET  = 2;
   localparam int LVL_TRIP_CLR  = 3;

   typedef enum logic [2:0] {
      CSR_OVERPOWER_LEVELS    = 3'd0,
      CSR_PERIOD_LEVELS       = 3'd1,
      CSR_FLOW_LEVELS         = 3'd2,
      CSR_VOID_LEVELS         = 3'd3,
      CSR_FLOW_ARM_POWER      = 3'd4,
      CSR_MIN_VALID_DETECTORS = 3'd5,
      CSR_SHUTDOWN_POWER      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_ALARM   = 2'd1,
      MODE_TRIPPED = 2'd2,
      MODE_SAFE    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [63:0]            overpower_levels;
      logic [63:0]            period_levels;
      logic [63:0]            flow_levels;
      logic [63:0]            void_levels;
      logic [15:0]            flow_arm_power;
      logic [COUNT_WIDTH-1:0] min_valid_detectors;
      logic [15:0]            shutdown_power;
   } cfg_type;

   typedef struct packed {
      logic [15:0]           power;
      logic signed [15:0]    period;
      logic [15:0]           coolant_flow;
      logic [15:0]           void_fraction;
      logic [MASK_WIDTH-1:0] detector_valid_mask;
      logic                  manual_scram;
      logic                  rods_fully_inserted;
      logic                  reset_req;
   } req_type;

   typedef struct packed {
      logic [1:0]            mode;
      logic                  scram;
      logic [COND_COUNT-1:0] alarm_bits;
      logic [COND_COUNT-1:0] trip_active_bits;
      logic [COND_COUNT-1:0] trip_latched_bits;
      logic                  reset_refused;
   } rsp_type;

   typedef struct packed {
      logic [COND_COUNT-1:0] alarm_set;
      logic [COND_COUNT-1:0] alarm_clr;
      logic [COND_COUNT-1:0] trip_set;
      logic [COND_COUNT-1:0] trip_clr;
      logic                  manual;
      logic                  safe_ok;
      logic                  reset_req;
   } class_type;

   function automatic logic [CMP_WIDTH-1:0] level_of(input logic [63:0] packed_word,
                                                     input int k);
      logic [127:0] wide;
      wide = {64'd0, packed_word} >> (k * LEVEL_WIDTH);
      return CMP_WIDTH'(wide[LEVEL_WIDTH-1:0]);
   endfunction

   function automatic logic [CMP_WIDTH-1:0] widen(input logic [15:0] value);
      return CMP_WIDTH'(value);
   endfunction

endpackage

@@ design/ptl_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection scan request channel
// Valid and ready handshake carrying one process scan.
// ----------------------------------------------------------------------------
interface ptl_req_if;
   logic                              valid;
   logic                              ready;
   logic [15:0]                       power;
   logic signed [15:0]                period;
   logic [15:0]                       coolant_flow;
   logic [15:0]                       void_fraction;
   logic [ptl_pkg::MASK_WIDTH-1:0]    detector_valid_mask;
   logic                              manual_scram;
   logic                              rods_fully_inserted;
   logic                              reset_req;

   modport source (output valid, power, period, coolant_flow, void_fraction,
                   detector_valid_mask, manual_scram, rods_fully_inserted, reset_req,
                   input ready);
   modport sink (input valid, power, period, coolant_flow, void_fraction,
                 detector_valid_mask, manual_scram, rods_fully_inserted, reset_req,
                 output ready);
endinterface

@@ design/ptl_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection scan response channel
// Valid and ready handshake carrying the mode, scram and condition bits.
// ----------------------------------------------------------------------------
interface ptl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        mode;
   logic                              scram;
   logic [ptl_pkg::COND_COUNT-1:0]    alarm_bits;
   logic [ptl_pkg::COND_COUNT-1:0]    trip_active_bits;
   logic [ptl_pkg::COND_COUNT-1:0]    trip_latched_bits;
   logic                              reset_refused;

   modport source (output valid, mode, scram, alarm_bits, trip_active_bits,
                   trip_latched_bits, reset_refused, input ready);
   modport sink (input valid, mode, scram, alarm_bits, trip_active_bits,
                 trip_latched_bits, reset_refused, output ready);
endinterface

@@ design/ptl_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection configuration write channel
// Valid and ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ptl_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/protection_trip_logic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection trip logic
// Per-scan alarm and trip evaluation with hysteresis, trip latching and a
// four-mode scram machine.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req      in         one process scan per request
//  rsp      out        mode, scram, alarm, trip and latch bits, reset refusal
//  csr      in         register index and 64-bit write data
//
// One request a cycle is sustained while the response side does not stall;
// a request's response passes through the queue and then the response
// register, while the classifier is combinational. The two-entry queue lets
// the request side take two more requests while a response waits. Reset
// zeroes configuration and control state, not queue entries or response data.
// ----------------------------------------------------------------------------
module protection_trip_logic (
   input logic       clock,
   input logic       reset,
   ptl_req_if.sink   req,
   ptl_rsp_if.source rsp,
   ptl_csr_if.sink   csr
);
   import ptl_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   req_type   req_item;
   class_type class_item;
   class_type queue_item;
   logic      queue_not_full;
   logic      queue_not_empty;
   logic      queue_pop;
   rsp_type   rsp_item;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_OVERPOWER_LEVELS:    cfg_in.overpower_levels    = csr.data;
            CSR_PERIOD_LEVELS:       cfg_in.period_levels       = csr.data;
            CSR_FLOW_LEVELS:         cfg_in.flow_levels         = csr.data;
            CSR_VOID_LEVELS:         cfg_in.void_levels         = csr.data;
            CSR_FLOW_ARM_POWER:      cfg_in.flow_arm_power      = csr.data[15:0];
            CSR_MIN_VALID_DETECTORS: cfg_in.min_valid_detectors = csr.data[COUNT_WIDTH-1:0];
            CSR_SHUTDOWN_POWER:      cfg_in.shutdown_power      = csr.data[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.power               = req.power;
   assign req_item.period              = req.period;
   assign req_item.coolant_flow        = req.coolant_flow;
   assign req_item.void_fraction       = req.void_fraction;
   assign req_item.detector_valid_mask = req.detector_valid_mask;
   assign req_item.manual_scram        = req.manual_scram;
   assign req_item.rods_fully_inserted = req.rods_fully_inserted;
   assign req_item.reset_req           = req.reset_req;

   assign req.ready = queue_not_full;

   ptl_front u_front (
      .req_in    (req_item),
      .cfg_in    (cfg_ff),
      .class_out (class_item)
   );

   ptl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req.valid && queue_not_full),
      .push_data (class_item),
      .not_full  (queue_not_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_item)
   );

   ptl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item_in    (queue_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_out    (rsp_item)
   );

   assign rsp.mode              = rsp_item.mode;
   assign rsp.scram             = rsp_item.scram;
   assign rsp.alarm_bits        = rsp_item.alarm_bits;
   assign rsp.trip_active_bits  = rsp_item.trip_active_bits;
   assign rsp.trip_latched_bits = rsp_item.trip_latched_bits;
   assign rsp.reset_refused     = rsp_item.reset_refused;

endmodule

@@ design/ptl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection scan classifier
// Compares one scan against the configured levels and gives set and clear
// flags for every alarm and trip condition.
// ----------------------------------------------------------------------------
module ptl_front (
   input  ptl_pkg::req_type   req_in,
   input  ptl_pkg::cfg_type   cfg_in,
   output ptl_pkg::class_type class_out
);
   import ptl_pkg::*;

   logic [CMP_WIDTH-1:0]   pwr;
   logic [CMP_WIDTH-1:0]   per;
   logic [CMP_WIDTH-1:0]   flow;
   logic [CMP_WIDTH-1:0]   vd;
   logic                   per_positive;
   logic                   flow_armed;
   logic                   sensor_fault;
   logic [COUNT_WIDTH-1:0] valid_count;
   logic [COND_COUNT-1:0]  set_bits [2];
   logic [COND_COUNT-1:0]  clr_bits [2];

   assign pwr          = widen(req_in.power);
   assign per          = widen(req_in.period);
   assign flow         = widen(req_in.coolant_flow);
   assign vd           = widen(req_in.void_fraction);
   assign per_positive = !req_in.period[15] && (req_in.period != 16'sd0);
   assign flow_armed   = req_in.power > cfg_in.flow_arm_power;

   always_comb begin
      valid_count = '0;
      for (int i = 0; i < MASK_WIDTH; i++) begin
         if (i < DETECTOR_COUNT) begin
            valid_count = valid_count + COUNT_WIDTH'(req_in.detector_valid_mask[i]);
         end
      end
   end

   assign sensor_fault = valid_count < cfg_in.min_valid_detectors;

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         set_bits[s][B_OVERPOWER] = pwr > level_of(cfg_in.overpower_levels, 2 * s);
         clr_bits[s][B_OVERPOWER] = pwr < level_of(cfg_in.overpower_levels, 2 * s + 1);
         set_bits[s][B_PERIOD] = per_positive
                                 && (per < level_of(cfg_in.period_levels, 2 * s));
         clr_bits[s][B_PERIOD] = !per_positive
                                 || (per > level_of(cfg_in.period_levels, 2 * s + 1));
         set_bits[s][B_FLOW] = flow_armed && (flow < level_of(cfg_in.flow_levels, 2 * s));
         clr_bits[s][B_FLOW] = !flow_armed
                               || (flow > level_of(cfg_in.flow_levels, 2 * s + 1));
         set_bits[s][B_VOID] = vd > level_of(cfg_in.void_levels, 2 * s);
         clr_bits[s][B_VOID] = vd < level_of(cfg_in.void_levels, 2 * s + 1);
         set_bits[s][B_SENSOR] = sensor_fault;
         clr_bits[s][B_SENSOR] = !sensor_fault;
         set_bits[s][B_MANUAL] = req_in.manual_scram;
         clr_bits[s][B_MANUAL] = !req_in.manual_scram;
      end
   end

   assign class_out.alarm_set = set_bits[LVL_ALARM_SET];
   assign class_out.alarm_clr = clr_bits[LVL_ALARM_SET];
   assign class_out.trip_set  = set_bits[LVL_TRIP_SET / 2];
   assign class_out.trip_clr  = clr_bits[LVL_TRIP_CLR / 2];
   assign class_out.manual    = req_in.manual_scram;
   assign class_out.safe_ok   = req_in.rods_fully_inserted
                                && (req_in.power < cfg_in.shutdown_power);
   assign class_out.reset_req = req_in.reset_req;

endmodule

@@ design/ptl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classified scan queue
// Two-entry queue between the classifier and the mode machine.
// ----------------------------------------------------------------------------
module ptl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ptl_pkg::class_type push_data,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output ptl_pkg::class_type pop_data
);
   import ptl_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   class_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff;
   logic [PTR_WIDTH-1:0]    wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff;
   logic [PTR_WIDTH-1:0]    rd_ptr_in;
   logic [CNT_WIDTH-1:0]    count_ff;
   logic [CNT_WIDTH-1:0]    count_in;

   assign not_full  = count_ff != CNT_WIDTH'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/ptl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection mode machine
// Applies hysteresis to the condition bits, latches trips, runs the mode
// machine and holds the response register.
// ----------------------------------------------------------------------------
module ptl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  ptl_pkg::class_type item_in,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ptl_pkg::rsp_type   rsp_out
);
   import ptl_pkg::*;

   mode_type              mode_ff;
   mode_type              mode_in;
   logic [COND_COUNT-1:0] alarm_ff;
   logic [COND_COUNT-1:0] alarm_in;
   logic [COND_COUNT-1:0] trip_ff;
   logic [COND_COUNT-1:0] trip_in;
   logic [COND_COUNT-1:0] latch_ff;
   logic [COND_COUNT-1:0] latch_in;
   logic [COND_COUNT-1:0] latch_or;
   logic                  grant;
   logic                  refused;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   assign item_pop = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int i = 0; i < COND_COUNT; i++) begin
         alarm_in[i] = item_in.alarm_set[i] ? 1'b1 :
                       (item_in.alarm_clr[i] ? 1'b0 : alarm_ff[i]);
         trip_in[i]  = item_in.trip_set[i] ? 1'b1 :
                       (item_in.trip_clr[i] ? 1'b0 : trip_ff[i]);
      end
   end

   assign latch_or = latch_ff | trip_in;
   assign grant    = item_in.reset_req && (trip_in == '0) && !item_in.manual;

   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_NORMAL: begin
            if (latch_or != '0) begin
               mode_in = MODE_TRIPPED;
            end else if (alarm_in != '0) begin
               mode_in = MODE_ALARM;
            end
         end
         MODE_ALARM: begin
            if (latch_or != '0) begin
               mode_in = MODE_TRIPPED;
            end else if (alarm_in == '0) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_TRIPPED: begin
            if (item_in.safe_ok) begin
               mode_in = MODE_SAFE;
            end
         end
         MODE_SAFE: begin
            if (grant) begin
               mode_in = MODE_NORMAL;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase
   end

   always_comb begin
      latch_in = latch_or;
      refused  = 1'b0;
      case (mode_ff)
         MODE_TRIPPED: begin
            refused = item_in.reset_req;
         end
         MODE_SAFE: begin
            if (grant) begin
               latch_in = '0;
            end
            refused = item_in.reset_req && !grant;
         end
         default: begin
            refused = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_in.mode              = mode_in;
      rsp_in.scram             = (mode_in == MODE_TRIPPED) || (mode_in == MODE_SAFE);
      rsp_in.alarm_bits        = alarm_in;
      rsp_in.trip_active_bits  = trip_in;
      rsp_in.trip_latched_bits = latch_in;
      rsp_in.reset_refused     = refused;
   end

   assign rsp_valid_in = item_pop || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         alarm_ff     <= '0;
         trip_ff      <= '0;
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            mode_ff  <= mode_in;
            alarm_ff <= alarm_in;
            trip_ff  <= trip_in;
            latch_ff <= latch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

@@ tb/sv/protection_trip_logic_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection trip logic testbench
// Drives process scans and register writes into the protection trip logic.
// A scoreboard predicts the mode, scram, condition bits and reset refusal of
// every scan and compares them in order with the responses. Register
// settings run from plausible plant levels to all-zero and all-ones levels,
// and the phases apply patterns of sender gaps and receiver back-pressure,
// the first and the last phase sharing the one with neither.
// ----------------------------------------------------------------------------
module protection_trip_logic_tb;
   import ptl_pkg::*;

   class trip_scoreboard;
      cfg_type    cfg;
      mode_type   mode_q;
      logic [5:0] alarm_q;
      logic [5:0] trip_q;
      logic [5:0] latch_q;
      rsp_type    expected_results[$];
      int         error_count;
      int         scan_count;
      int         result_count;
      int         trip_count;
      int         safe_count;
      int         grant_count;
      int         refusal_count;

      function new();
         cfg     = '0;
         mode_q  = MODE_NORMAL;
         alarm_q = '0;
         trip_q  = '0;
         latch_q = '0;
      endfunction

      function void write_register(csr_index_type idx, logic [63:0] data);
         case (idx)
            CSR_OVERPOWER_LEVELS:    cfg.overpower_levels = data;
            CSR_PERIOD_LEVELS:       cfg.period_levels = data;
            CSR_FLOW_LEVELS:         cfg.flow_levels = data;
            CSR_VOID_LEVELS:         cfg.void_levels = data;
            CSR_FLOW_ARM_POWER:      cfg.flow_arm_power = data[15:0];
            CSR_MIN_VALID_DETECTORS: cfg.min_valid_detectors = data[COUNT_WIDTH-1:0];
            CSR_SHUTDOWN_POWER:      cfg.shutdown_power = data[15:0];
            default: ;
         endcase
      endfunction

      function logic [15:0] level(logic [63:0] word, int k);
         return word[k*LEVEL_WIDTH +: LEVEL_WIDTH];
      endfunction

      function bit high_check(bit held, logic [15:0] v, logic [15:0] set_lvl,
                              logic [15:0] clr_lvl);
         if (v > set_lvl) return 1'b1;
         if (v < clr_lvl) return 1'b0;
         return held;
      endfunction

      function bit low_check(bit held, logic [15:0] v, logic [15:0] set_lvl,
                             logic [15:0] clr_lvl);
         if (v < set_lvl) return 1'b1;
         if (v > clr_lvl) return 1'b0;
         return held;
      endfunction

      function logic [5:0] evaluate(logic [5:0] prev, int off, req_type s, bit fault);
         logic [5:0] bits;
         bits = prev;
         bits[B_OVERPOWER] = high_check(bits[B_OVERPOWER], s.power,
                                        level(cfg.overpower_levels, off),
                                        level(cfg.overpower_levels, off + 1));
         if ($signed(s.period) > 0)
            bits[B_PERIOD] = low_check(bits[B_PERIOD], s.period,
                                       level(cfg.period_levels, off),
                                       level(cfg.period_levels, off + 1));
         else
            bits[B_PERIOD] = 1'b0;
         if (s.power > cfg.flow_arm_power)
            bits[B_FLOW] = low_check(bits[B_FLOW], s.coolant_flow,
                                     level(cfg.flow_levels, off),
                                     level(cfg.flow_levels, off + 1));
         else
            bits[B_FLOW] = 1'b0;
         bits[B_VOID] = high_check(bits[B_VOID], s.void_fraction,
                                   level(cfg.void_levels, off),
                                   level(cfg.void_levels, off + 1));
         bits[B_SENSOR] = fault;
         bits[B_MANUAL] = s.manual_scram;
         return bits;
      endfunction

      function rsp_type predict_scan(req_type s);
         bit      fault;
         bit      refused;
         rsp_type r;
         fault   = $countones(s.detector_valid_mask) < int'(cfg.min_valid_detectors);
         alarm_q = evaluate(alarm_q, LVL_ALARM_SET, s, fault);
         trip_q  = evaluate(trip_q, LVL_TRIP_SET, s, fault);
         latch_q = latch_q | trip_q;
         refused = 1'b0;
         case (mode_q)
            MODE_NORMAL, MODE_ALARM: begin
               if (latch_q != 0) begin
                  mode_q = MODE_TRIPPED;
                  trip_count++;
               end else if (alarm_q != 0) begin
                  mode_q = MODE_ALARM;
               end else begin
                  mode_q = MODE_NORMAL;
               end
            end
            MODE_TRIPPED: begin
               if (s.rods_fully_inserted && s.power < cfg.shutdown_power) begin
                  mode_q = MODE_SAFE;
                  safe_count++;
               end
               refused = s.reset_req;
            end
            default: begin
               if (s.reset_req) begin
                  if (trip_q == 0 && !s.manual_scram) begin
                     latch_q = '0;
                     mode_q  = MODE_NORMAL;
                     grant_count++;
                  end else begin
                     refused = 1'b1;
                  end
               end
            end
         endcase
         refusal_count += refused;
         r.mode              = mode_q;
         r.scram             = (mode_q == MODE_TRIPPED) || (mode_q == MODE_SAFE);
         r.alarm_bits        = alarm_q;
         r.trip_active_bits  = trip_q;
         r.trip_latched_bits = latch_q;
         r.reset_refused     = refused;
         return r;
      endfunction

      function void note_scan(req_type s);
         expected_results.push_back(predict_scan(s));
         scan_count++;
      endfunction

      task report_mismatch(string what, int got, int want);
         if (error_count < 50)
            $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         error_count++;
      endtask

      task check_result(rsp_type r);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("response with no request outstanding", r, 0);
         end else begin
            want = expected_results.pop_front();
            result_count++;
            if (r.mode !== want.mode)
               report_mismatch("mode", r.mode, want.mode);
            if (r.scram !== want.scram)
               report_mismatch("scram", r.scram, want.scram);
            if (r.alarm_bits !== want.alarm_bits)
               report_mismatch("alarm_bits", r.alarm_bits, want.alarm_bits);
            if (r.trip_active_bits !== want.trip_active_bits)
               report_mismatch("trip_active_bits", r.trip_active_bits,
                               want.trip_active_bits);
            if (r.trip_latched_bits !== want.trip_latched_bits)
               report_mismatch("trip_latched_bits", r.trip_latched_bits,
                               want.trip_latched_bits);
            if (r.reset_refused !== want.reset_refused)
               report_mismatch("reset_refused", r.reset_refused, want.reset_refused);
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   phase_count;

   trip_scoreboard board;

   ptl_req_if req_ch ();
   ptl_rsp_if rsp_ch ();
   ptl_csr_if csr_ch ();

   protection_trip_logic dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{mode: rsp_ch.mode, scram: rsp_ch.scram, alarm_bits: rsp_ch.alarm_bits,
                 trip_active_bits: rsp_ch.trip_active_bits,
                 trip_latched_bits: rsp_ch.trip_latched_bits,
                 reset_refused: rsp_ch.reset_refused};
         board.check_result(got);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function logic [63:0] pack_levels(logic [15:0] a_set, logic [15:0] a_clr,
                                     logic [15:0] t_set, logic [15:0] t_clr);
      return {t_clr, t_set, a_clr, a_set};
   endfunction

   function req_type make_scan(int pwr, int per, int flow, int vd, int mask,
                               bit manual, bit rods, bit rst);
      req_type s;
      s.power               = 16'(pwr);
      s.period              = 16'(per);
      s.coolant_flow        = 16'(flow);
      s.void_fraction       = 16'(vd);
      s.detector_valid_mask = 8'(mask);
      s.manual_scram        = manual;
      s.rods_fully_inserted = rods;
      s.reset_req           = rst;
      return s;
   endfunction

   function req_type random_scan();
      req_type s;
      int      r;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         // A quiet plant at low power, the usual path back to normal.
         s = make_scan($urandom_range(0, 400), ($urandom_range(0, 1) ? 0 : 3000),
                       12000, 5000, 8'hFF, 1'b0, $urandom_range(0, 3) != 0,
                       $urandom_range(0, 1));
      end else begin
         r = $urandom_range(0, 99);
         s.power = (r < 10) ? 16'($urandom()) :
                   (r < 25) ? 16'($urandom_range(0, 2000)) : 16'($urandom_range(15000, 19000));
         r = $urandom_range(0, 99);
         s.period = (r < 10) ? 16'($urandom()) :
                    (r < 20) ? -16'($urandom_range(0, 100)) : 16'($urandom_range(500, 2000));
         r = $urandom_range(0, 99);
         s.coolant_flow = (r < 10) ? 16'($urandom()) : 16'($urandom_range(6000, 12000));
         r = $urandom_range(0, 99);
         s.void_fraction = (r < 10) ? 16'($urandom()) : 16'($urandom_range(7000, 12000));
         s.detector_valid_mask = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom());
         s.manual_scram        = ($urandom_range(0, 99) < 4);
         s.rods_fully_inserted = ($urandom_range(0, 99) < 40);
         s.reset_req           = ($urandom_range(0, 99) < 25);
      end
      return s;
   endfunction

   task write_register(csr_index_type idx, logic [63:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.write_register(idx, data);
   endtask

   task apply_settings(logic [63:0] op, logic [63:0] per, logic [63:0] flow,
                       logic [63:0] vd, logic [15:0] arm, logic [3:0] min_det,
                       logic [15:0] shutdown);
      write_register(CSR_OVERPOWER_LEVELS, op);
      write_register(CSR_PERIOD_LEVELS, per);
      write_register(CSR_FLOW_LEVELS, flow);
      write_register(CSR_VOID_LEVELS, vd);
      write_register(CSR_FLOW_ARM_POWER, 64'(arm));
      write_register(CSR_MIN_VALID_DETECTORS, 64'(min_det));
      write_register(CSR_SHUTDOWN_POWER, 64'(shutdown));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      phase_count++;
   endtask

   task send_scan(req_type s);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      end
      req_ch.valid               <= 1'b1;
      req_ch.power               <= s.power;
      req_ch.period              <= s.period;
      req_ch.coolant_flow        <= s.coolant_flow;
      req_ch.void_fraction       <= s.void_fraction;
      req_ch.detector_valid_mask <= s.detector_valid_mask;
      req_ch.manual_scram        <= s.manual_scram;
      req_ch.rods_fully_inserted <= s.rods_fully_inserted;
      req_ch.reset_req           <= s.reset_req;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_scan(s);
   endtask

   task drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_results.size() != 0) @(posedge clock);
   endtask

   task run_random(int count);
      repeat (count) begin
         if ($urandom_range(0, 149) == 0) drain_responses();
         send_scan(random_scan());
      end
   endtask

   task run_directed();
      send_scan(make_scan(16000, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b0, 1'b1));
      send_scan(make_scan(17300, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(16900, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(16000, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(16000, 2000, 14000, 9000, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(16000, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(16000, 2000, 9000, 4000, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(16000, 32767, 14000, 4000, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(65535, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(16000, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b0, 1'b1));
      send_scan(make_scan(0, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b1, 1'b1));
      send_scan(make_scan(0, 2000, 14000, 4000, 8'hFF, 1'b1, 1'b1, 1'b1));
      send_scan(make_scan(0, 1, 14000, 4000, 8'hFF, 1'b0, 1'b1, 1'b1));
      send_scan(make_scan(0, 0, 14000, 4000, 8'hFF, 1'b0, 1'b1, 1'b1));
      send_scan(make_scan(0, -32768, 0, 65535, 8'hFF, 1'b0, 1'b0, 1'b0));
      send_scan(make_scan(200, 2000, 14000, 0, 8'hFF, 1'b0, 1'b1, 1'b0));
      send_scan(make_scan(200, 2000, 14000, 0, 8'h1F, 1'b0, 1'b1, 1'b1));
      send_scan(make_scan(200, 2000, 14000, 0, 8'hFF, 1'b0, 1'b1, 1'b1));
      send_scan(make_scan(16000, 700, 14000, 4000, 8'h3F, 1'b1, 1'b0, 1'b0));
      send_scan(make_scan(100, 700, 14000, 4000, 8'hFF, 1'b0, 1'b1, 1'b0));
      send_scan(make_scan(100, 2000, 14000, 4000, 8'hFF, 1'b0, 1'b1, 1'b1));
      send_scan(make_scan(16000, 2000, 14000, 4000, 8'h00, 1'b0, 1'b0, 1'b0));
   endtask

   task set_idling(int phase);
      case (phase % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 79; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 79; end
         default: begin idle_pct = 31; stall_pct = 31; end
      endcase
   endtask

   initial begin
      #2_000_000;
      $display("protection_trip_logic: mismatch");
      $finish;
   end

   initial begin
      logic [63:0] plant_op;
      logic [63:0] plant_per;
      logic [63:0] plant_flow;
      logic [63:0] plant_void;
      board       = new();
      phase_count = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      clock       = 1'b0;
      reset       = 1'b1;
      req_ch.valid               <= 1'b0;
      req_ch.power               <= '0;
      req_ch.period              <= '0;
      req_ch.coolant_flow        <= '0;
      req_ch.void_fraction       <= '0;
      req_ch.detector_valid_mask <= '0;
      req_ch.manual_scram        <= 1'b0;
      req_ch.rods_fully_inserted <= 1'b0;
      req_ch.reset_req           <= 1'b0;
      csr_ch.valid               <= 1'b0;
      csr_ch.index               <= '0;
      csr_ch.data                <= '0;
      plant_op   = pack_levels(17203, 16800, 18022, 17500);
      plant_per  = pack_levels(1280, 1400, 640, 768);
      plant_flow = pack_levels(9830, 10500, 6554, 7000);
      plant_void = pack_levels(8192, 7800, 11469, 11000);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0);
      apply_settings(plant_op, plant_per, plant_flow, plant_void, 1638, 6, 328);
      run_directed();
      run_random(350);
      drain_responses();

      set_idling(1);
      apply_settings('1, '1, '1, '1, 16'hFFFF, 4'd8, 16'hFFFF);
      run_random(370);
      drain_responses();

      set_idling(2);
      apply_settings('0, '0, '0, '0, 16'h0000, 4'd0, 16'h0000);
      run_random(370);
      drain_responses();

      set_idling(3);
      apply_settings({$urandom(), $urandom()}, {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, {$urandom(), $urandom()},
                     16'($urandom()), 4'($urandom_range(0, 8)), 16'($urandom()));
      run_random(370);
      drain_responses();

      set_idling(4);
      apply_settings(plant_op, plant_per, plant_flow, plant_void, 0, 3, 2000);
      run_random(370);
      drain_responses();

      repeat (10) @(posedge clock);
      $display("Covered %0d scans and %0d responses over %0d register settings.",
               board.scan_count, board.result_count, phase_count);
      $display("Saw %0d trips, %0d safe shutdowns, %0d granted and %0d refused resets.",
               board.trip_count, board.safe_count, board.grant_count, board.refusal_count);
      if (board.error_count == 0)
         $display("protection_trip_logic: match");
      else
         $display("protection_trip_logic: mismatch");
      $finish;
   end

endmodule
